// ===== design/shc_pkg.sv =====
// ----------------------------------------------------------------------------
// shc_pkg
// Shared widths, request codes and constants for the substring hash compare
// unit.
// ----------------------------------------------------------------------------
package shc_pkg;

    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int POS_W  = 13;
    localparam int WORD_W = 64;
    localparam int HALF_W = 32;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [HALF_W-1:0] half_t;
    typedef logic [REQ_W-1:0]  req_t;

    localparam req_t REQ_APPEND  = 2'd0;
    localparam req_t REQ_COMPARE = 2'd1;
    localparam req_t REQ_CLEAR   = 2'd2;

    // character value is the byte less 'a' - 1, modulo 2^64
    localparam word_t CHAR_BIAS  = 64'd96;
    localparam word_t BASE_RESET = 64'd29;
    localparam word_t HASH_EMPTY = 64'd0;
    localparam word_t POW_EMPTY  = 64'd1;

endpackage

// ===== design/shc_mul64.sv =====
// ----------------------------------------------------------------------------
// shc_mul64
// Low 64 bits of a 64 x 64 product, built from three 32 x 32 partial
// products in steps LL, LH and HL on one multiplier.
// ----------------------------------------------------------------------------
module shc_mul64
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  shc_pkg::word_t op_a,
    input  shc_pkg::word_t op_b,
    output logic          busy,
    output shc_pkg::word_t product
);

    localparam int HW = shc_pkg::HALF_W;

    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_LH = 2'd1;
    localparam logic [1:0] STEP_HL = 2'd2;

    shc_pkg::word_t a_reg;
    shc_pkg::word_t b_reg;
    shc_pkg::word_t acc_reg;
    shc_pkg::word_t acc_next;
    logic [1:0]     step_reg;
    logic           busy_reg;
    shc_pkg::half_t mx;
    shc_pkg::half_t my;
    shc_pkg::word_t pp;

    always_comb
    begin
        unique case (step_reg)
            STEP_LL:
            begin
                mx = a_reg[HW-1:0];
                my = b_reg[HW-1:0];
            end
            STEP_LH:
            begin
                mx = a_reg[HW-1:0];
                my = b_reg[2*HW-1:HW];
            end
            STEP_HL:
            begin
                mx = a_reg[2*HW-1:HW];
                my = b_reg[HW-1:0];
            end
            default:
            begin
                mx = '0;
                my = '0;
            end
        endcase
    end

    // 32 x 32 unsigned product, zero-extended operands
    assign pp = shc_pkg::WORD_W'(mx) * shc_pkg::WORD_W'(my);

    always_comb
    begin
        if (step_reg == STEP_LL)
        begin
            acc_next = pp;
        end
        else
        begin
            acc_next = acc_reg + {pp[HW-1:0], {HW{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_LL;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_LL;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == STEP_HL)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

// ===== design/shc_store.sv =====
// ----------------------------------------------------------------------------
// shc_store
// Prefix hash and base power memories, one port each, registered read.
// Entry zero is never written and reads as the empty-string values.
// ----------------------------------------------------------------------------
module shc_store
#(
    parameter int DEPTH = 4097,
    parameter int AW    = 13
)
(
    input  logic           clk,
    input  logic           we,
    input  logic [AW-1:0]  waddr,
    input  shc_pkg::word_t wdata_h,
    input  shc_pkg::word_t wdata_p,
    input  logic [AW-1:0]  raddr_h,
    input  logic [AW-1:0]  raddr_p,
    output shc_pkg::word_t rdata_h,
    output shc_pkg::word_t rdata_p
);

    shc_pkg::word_t mem_h [DEPTH];
    shc_pkg::word_t mem_p [DEPTH];
    shc_pkg::word_t q_h_reg;
    shc_pkg::word_t q_p_reg;
    logic           zero_h_reg;
    logic           zero_p_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_h[waddr] <= wdata_h;
        end
        else
        begin
            q_h_reg    <= mem_h[raddr_h];
            zero_h_reg <= (raddr_h == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_p[waddr] <= wdata_p;
        end
        else
        begin
            q_p_reg    <= mem_p[raddr_p];
            zero_p_reg <= (raddr_p == '0);
        end
    end

    assign rdata_h = zero_h_reg ? shc_pkg::HASH_EMPTY : q_h_reg;
    assign rdata_p = zero_p_reg ? shc_pkg::POW_EMPTY  : q_p_reg;

endmodule

// ===== design/substring_hash_compare_unit.sv =====
// ----------------------------------------------------------------------------
// substring_hash_compare_unit
// Polynomial rolling hash over an appended string; compares two substrings
// by their hashes modulo 2^64.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_ready   req_type, char_code, first_left,
//                                     first_right, second_left, second_right
//   out      out  out_valid/out_ready ranges_equal, error_flag
//   cfg      in   cfg_we              cfg_wdata (hash_base)
//
// Append: three-step 32-bit multiply, then store write.
// Compare: six reads over states CRD1 to CRD4, two staggered
// multiplies, subtract, result load. One item is in flight at a time.
// Clear, unused request: back to idle; rejected item: via the final state.
// Reset: no clearing pass; entry zero of each store is fixed in logic.
// A result waiting on out_ready holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module substring_hash_compare_unit
#(
    parameter int MAX_LEN = 4096
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [shc_pkg::REQ_W-1:0]    req_type,
    input  logic [shc_pkg::CHAR_W-1:0]   char_code,
    input  logic [shc_pkg::POS_W-1:0]    first_left,
    input  logic [shc_pkg::POS_W-1:0]    first_right,
    input  logic [shc_pkg::POS_W-1:0]    second_left,
    input  logic [shc_pkg::POS_W-1:0]    second_right,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         ranges_equal,
    output logic                         error_flag,
    input  logic                         cfg_we,
    input  logic [shc_pkg::WORD_W-1:0]   cfg_wdata
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int CMP_W = ((LEN_W > shc_pkg::POS_W) ? LEN_W : shc_pkg::POS_W) + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_AWAIT = 4'd1;
    localparam logic [3:0] S_CRD1  = 4'd2;
    localparam logic [3:0] S_CRD2  = 4'd3;
    localparam logic [3:0] S_CRD3  = 4'd4;
    localparam logic [3:0] S_CRD4  = 4'd5;
    localparam logic [3:0] S_CRD5  = 4'd6;
    localparam logic [3:0] S_CWAIT = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    shc_pkg::word_t   base_reg;
    shc_pkg::word_t   tail_h_reg;
    shc_pkg::word_t   tail_p_reg;
    logic             res_err_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             eq_reg;
    logic             err_reg;

    logic [shc_pkg::CHAR_W-1:0] char_reg;
    logic [LEN_W-1:0] lm0_reg;
    logic [LEN_W-1:0] n0_reg;
    logic [LEN_W-1:0] r0_reg;
    logic [LEN_W-1:0] lm1_reg;
    logic [LEN_W-1:0] n1_reg;
    logic [LEN_W-1:0] r1_reg;
    shc_pkg::word_t   hr0_reg;
    shc_pkg::word_t   hr1_reg;
    shc_pkg::word_t   h0_reg;
    shc_pkg::word_t   h1_reg;

    logic             accept;
    logic             full;
    logic             app_go;
    logic [CMP_W-1:0] l0x;
    logic [CMP_W-1:0] r0x;
    logic [CMP_W-1:0] l1x;
    logic [CMP_W-1:0] r1x;
    logic [CMP_W-1:0] lenx;
    logic             ok0;
    logic             ok1;

    logic             mul_idle;
    logic             start_a;
    logic             start_b;
    logic             busy_a;
    logic             busy_b;
    shc_pkg::word_t   opa_a;
    shc_pkg::word_t   opb_a;
    shc_pkg::word_t   opa_b;
    shc_pkg::word_t   opb_b;
    shc_pkg::word_t   prod_a;
    shc_pkg::word_t   prod_b;

    logic             st_we;
    logic [LEN_W-1:0] st_waddr;
    shc_pkg::word_t   st_wdata_h;
    logic [LEN_W-1:0] raddr_h;
    logic [LEN_W-1:0] raddr_p;
    shc_pkg::word_t   rdata_h;
    shc_pkg::word_t   rdata_p;
    logic             load_out;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign full     = (len_reg == LEN_W'(MAX_LEN));
    assign app_go   = accept && (req_type == shc_pkg::REQ_APPEND) && !full;
    assign mul_idle = !busy_a && !busy_b;

    assign l0x  = CMP_W'(first_left);
    assign r0x  = CMP_W'(first_right);
    assign l1x  = CMP_W'(second_left);
    assign r1x  = CMP_W'(second_right);
    assign lenx = CMP_W'(len_reg);
    assign ok0  = (l0x != '0) && ((r0x + CMP_W'(1)) >= l0x) && (r0x <= lenx);
    assign ok1  = (l1x != '0) && ((r1x + CMP_W'(1)) >= l1x) && (r1x <= lenx);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        shc_pkg::REQ_APPEND:  state_next = full ? S_FIN : S_AWAIT;
                        shc_pkg::REQ_COMPARE: state_next = (ok0 && ok1) ? S_CRD1 : S_FIN;
                        shc_pkg::REQ_CLEAR:   len_next   = '0;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_AWAIT:
            begin
                if (mul_idle)
                begin
                    len_next   = len_reg + LEN_W'(1);
                    state_next = S_IDLE;
                end
            end
            S_CRD1:  state_next = S_CRD2;
            S_CRD2:  state_next = S_CRD3;
            S_CRD3:  state_next = S_CRD4;
            S_CRD4:  state_next = S_CRD5;
            S_CRD5:  state_next = S_CWAIT;
            S_CWAIT:
            begin
                if (mul_idle)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign load_out = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            base_reg      <= shc_pkg::BASE_RESET;
            tail_h_reg    <= shc_pkg::HASH_EMPTY;
            tail_p_reg    <= shc_pkg::POW_EMPTY;
            res_err_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (accept)
            begin
                res_err_reg <= (req_type == shc_pkg::REQ_APPEND) ? 1'b1 : !(ok0 && ok1);
            end
            if (accept && (req_type == shc_pkg::REQ_CLEAR))
            begin
                tail_h_reg <= shc_pkg::HASH_EMPTY;
                tail_p_reg <= shc_pkg::POW_EMPTY;
            end
            else if (st_we)
            begin
                tail_h_reg <= st_wdata_h;
                tail_p_reg <= prod_b;
            end
        end
    end

    // operand capture and range hashes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_code;
            lm0_reg  <= LEN_W'(l0x - CMP_W'(1));
            n0_reg   <= LEN_W'(r0x + CMP_W'(1) - l0x);
            r0_reg   <= LEN_W'(r0x);
            lm1_reg  <= LEN_W'(l1x - CMP_W'(1));
            n1_reg   <= LEN_W'(r1x + CMP_W'(1) - l1x);
            r1_reg   <= LEN_W'(r1x);
        end
        if (state_reg == S_CRD4)
        begin
            hr0_reg <= rdata_h;
        end
        if (state_reg == S_CRD5)
        begin
            hr1_reg <= rdata_h;
        end
        if ((state_reg == S_CWAIT) && mul_idle)
        begin
            h0_reg <= hr0_reg - prod_a;
            h1_reg <= hr1_reg - prod_b;
        end
        if (load_out)
        begin
            eq_reg  <= !res_err_reg && (h0_reg == h1_reg);
            err_reg <= res_err_reg;
        end
    end

    // multipliers
    assign start_a = app_go || (state_reg == S_CRD2);
    assign start_b = app_go || (state_reg == S_CRD3);
    assign opa_a   = in_ready ? tail_h_reg : rdata_h;
    assign opb_a   = in_ready ? base_reg   : rdata_p;
    assign opa_b   = in_ready ? tail_p_reg : rdata_h;
    assign opb_b   = in_ready ? base_reg   : rdata_p;

    shc_mul64 u_mul_a
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_a),
        .op_a    (opa_a),
        .op_b    (opb_a),
        .busy    (busy_a),
        .product (prod_a)
    );

    shc_mul64 u_mul_b
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_b),
        .op_a    (opa_b),
        .op_b    (opb_b),
        .busy    (busy_b),
        .product (prod_b)
    );

    // store access
    assign st_we      = (state_reg == S_AWAIT) && mul_idle;
    assign st_waddr   = len_reg + LEN_W'(1);
    assign st_wdata_h = prod_a + (shc_pkg::WORD_W'(char_reg) - shc_pkg::CHAR_BIAS);

    always_comb
    begin
        raddr_h = '0;
        raddr_p = '0;
        unique case (state_reg)
            S_CRD1:
            begin
                raddr_h = lm0_reg;
                raddr_p = n0_reg;
            end
            S_CRD2:
            begin
                raddr_h = lm1_reg;
                raddr_p = n1_reg;
            end
            S_CRD3:  raddr_h = r0_reg;
            S_CRD4:  raddr_h = r1_reg;
            default: raddr_h = '0;
        endcase
    end

    shc_store
    #(
        .DEPTH (MAX_LEN + 1),
        .AW    (LEN_W)
    )
    u_store
    (
        .clk     (clk),
        .we      (st_we),
        .waddr   (st_waddr),
        .wdata_h (st_wdata_h),
        .wdata_p (prod_b),
        .raddr_h (raddr_h),
        .raddr_p (raddr_p),
        .rdata_h (rdata_h),
        .rdata_p (rdata_p)
    );

    assign out_valid    = out_valid_reg;
    assign ranges_equal = eq_reg;
    assign error_flag   = err_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> mul_idle)
        else $error("item taken while a multiply is running");

    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_LEN))
        else $error("loaded length beyond store depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        st_we |=> (len_reg == $past(len_reg) + LEN_W'(1)))
        else $error("store write without length step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_flag) |-> !ranges_equal)
        else $error("error result flagged as equal");

endmodule

// ===== tb/substring_hash_compare_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// substring_hash_compare_unit_test
// Drives appends, clears and two-range compares into the substring hash
// compare unit, and keeps its own rolling-hash image of the loaded string so
// that every verdict can be predicted. Results are checked in order, field by
// field. Both channels idle at random. The run covers several hash bases, a
// completely filled store and a long stretch of random traffic.
// ----------------------------------------------------------------------------
module substring_hash_compare_unit_test;

    localparam int   MAX_LEN       = 4096;
    localparam int   POS_MAX       = (1 << shc_pkg::POS_W) - 1;
    localparam int   SETTLE_CYCLES = 16;
    localparam int   RANDOM_ITEMS  = 1050;
    localparam int   PHASE_ITEMS   = 210;
    localparam shc_pkg::req_t REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic ranges_equal;
        logic error_flag;
    } verdict_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [shc_pkg::REQ_W-1:0]  req_type;
    logic [shc_pkg::CHAR_W-1:0] char_code;
    logic [shc_pkg::POS_W-1:0]  first_left;
    logic [shc_pkg::POS_W-1:0]  first_right;
    logic [shc_pkg::POS_W-1:0]  second_left;
    logic [shc_pkg::POS_W-1:0]  second_right;
    logic                       out_valid;
    logic                       out_ready;
    logic                       ranges_equal;
    logic                       error_flag;
    logic                       cfg_we;
    logic [shc_pkg::WORD_W-1:0] cfg_wdata;

    // string image: prefix hashes and base powers, both modulo 2^64
    shc_pkg::word_t model_base;
    shc_pkg::word_t model_prefix [0:MAX_LEN];
    shc_pkg::word_t model_power  [0:MAX_LEN];
    int             model_len;
    verdict_t       expected_verdicts [$];
    int             mismatches;
    int             items_sent;
    bit             send_idle_on;
    bit             take_idle_on;

    substring_hash_compare_unit #(
        .MAX_LEN (MAX_LEN)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .char_code    (char_code),
        .first_left   (first_left),
        .first_right  (first_right),
        .second_left  (second_left),
        .second_right (second_right),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .ranges_equal (ranges_equal),
        .error_flag   (error_flag),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(40_000_000);
        $display("[substring_hash_compare_unit] ERROR");
        $finish;
    end

    function automatic int draw_wait(input bit idle_on);
        if (!idle_on)
            return 0;
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return $urandom_range(0, 2);
            default: return $urandom_range(0, 16);
        endcase
    endfunction

    function automatic bit substring_hash(input int l, input int r,
            output shc_pkg::word_t h);
        h = shc_pkg::HASH_EMPTY;
        if (l < 1 || r + 1 < l || r > model_len)
            return 1'b0;
        h = model_prefix[r] - model_prefix[l-1] * model_power[r-l+1];
        return 1'b1;
    endfunction

    // updates the string image; returns 1 when the item yields a verdict
    function automatic bit apply_request(input shc_pkg::req_t req,
            input logic [shc_pkg::CHAR_W-1:0] code,
            input int fl, input int fr, input int sl, input int sr,
            output verdict_t v);
        shc_pkg::word_t h0;
        shc_pkg::word_t h1;
        bit             ok0;
        bit             ok1;
        v = '0;
        case (req)
            shc_pkg::REQ_APPEND:
            begin
                if (model_len >= MAX_LEN)
                begin
                    v.error_flag = 1'b1;
                    return 1'b1;
                end
                model_prefix[model_len+1] = model_prefix[model_len] * model_base
                    + ({{(shc_pkg::WORD_W-shc_pkg::CHAR_W){1'b0}}, code}
                       - shc_pkg::CHAR_BIAS);
                model_power[model_len+1]  = model_power[model_len] * model_base;
                model_len++;
            end
            shc_pkg::REQ_COMPARE:
            begin
                ok0 = substring_hash(fl, fr, h0);
                ok1 = substring_hash(sl, sr, h1);
                if (ok0 && ok1)
                    v.ranges_equal = (h0 == h1);
                else
                    v.error_flag = 1'b1;
                return 1'b1;
            end
            shc_pkg::REQ_CLEAR:
                model_len = 0;
            default:
                ;
        endcase
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic send_request(input shc_pkg::req_t req,
            input logic [shc_pkg::CHAR_W-1:0] code,
            input logic [shc_pkg::POS_W-1:0] fl, input logic [shc_pkg::POS_W-1:0] fr,
            input logic [shc_pkg::POS_W-1:0] sl, input logic [shc_pkg::POS_W-1:0] sr);
        int       gap;
        verdict_t v;
        gap = draw_wait(send_idle_on);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= req;
        char_code    <= code;
        first_left   <= fl;
        first_right  <= fr;
        second_left  <= sl;
        second_right <= sr;
        do @(posedge clk); while (in_ready !== 1'b1);
        if (apply_request(req, code, int'(fl), int'(fr), int'(sl), int'(sr), v))
            expected_verdicts.push_back(v);
        if (req != REQ_UNUSED)
            items_sent++;
    endtask

    function automatic logic [shc_pkg::POS_W-1:0] random_pos();
        return shc_pkg::POS_W'($urandom_range(0, POS_MAX));
    endfunction

    task automatic append_char(input logic [shc_pkg::CHAR_W-1:0] code);
        send_request(shc_pkg::REQ_APPEND, code, random_pos(), random_pos(),
                     random_pos(), random_pos());
    endtask

    task automatic compare_ranges(input int fl, input int fr, input int sl, input int sr);
        send_request(shc_pkg::REQ_COMPARE, shc_pkg::CHAR_W'($urandom_range(0, 255)),
                     shc_pkg::POS_W'(fl), shc_pkg::POS_W'(fr),
                     shc_pkg::POS_W'(sl), shc_pkg::POS_W'(sr));
    endtask

    task automatic clear_string();
        send_request(shc_pkg::REQ_CLEAR, shc_pkg::CHAR_W'($urandom_range(0, 255)),
                     random_pos(), random_pos(), random_pos(), random_pos());
    endtask

    // mostly letters from a small alphabet, so that equal substrings are common
    task automatic append_random_word(input int n, input int alphabet);
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
                append_char(shc_pkg::CHAR_W'($urandom_range(0, 255)));
            else
                append_char(shc_pkg::CHAR_W'(97 + $urandom_range(0, alphabet - 1)));
        end
    endtask

    task automatic compare_random_ranges(input int bad_pct);
        int k;
        int fl;
        int fr;
        int sl;
        int sr;
        k = $urandom_range(0, (model_len < 10) ? model_len : 10);
        if ($urandom_range(0, 9) == 0)
            k = $urandom_range(0, model_len);
        fl = $urandom_range(1, model_len - k + 1);
        fr = fl + k - 1;
        sl = ($urandom_range(0, 4) == 0) ? fl : $urandom_range(1, model_len - k + 1);
        sr = sl + k - 1;
        if ($urandom_range(0, 9) == 0)
            sr = sl + $urandom_range(0, model_len - sl + 1) - 1;
        if ($urandom_range(0, 99) < bad_pct)
        begin
            case ($urandom_range(0, 3))
                0:
                    fl = 0;
                1:
                begin
                    sl = $urandom_range(2, POS_MAX);
                    sr = $urandom_range(0, sl - 2);
                end
                2:
                    fr = $urandom_range(model_len + 1, POS_MAX);
                default:
                begin
                    fl = $urandom_range(0, POS_MAX);
                    fr = $urandom_range(0, POS_MAX);
                    sl = $urandom_range(0, POS_MAX);
                    sr = $urandom_range(0, POS_MAX);
                end
            endcase
        end
        compare_ranges(fl, fr, sl, sr);
    endtask

    // appends give no result, so the unit may still be busy after the last verdict
    task automatic drain_and_settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_hash_base(input shc_pkg::word_t value);
        drain_and_settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        model_base = value;
    endtask

    task automatic test_directed_cases();
        compare_ranges(1, 0, 1, 0);
        compare_ranges(0, 0, 1, 0);
        append_char(8'd97);
        append_char(8'd98);
        append_char(8'd97);
        append_char(8'd98);
        append_char(8'd0);
        append_char(8'd255);
        append_char(8'd96);
        compare_ranges(1, 2, 3, 4);
        compare_ranges(1, 2, 2, 3);
        compare_ranges(5, 5, 6, 6);
        compare_ranges(3, 2, 8, 7);
        // a character of value zero hashes like the empty range
        compare_ranges(7, 7, 1, 0);
        compare_ranges(1, 1, 1, 0);
        compare_ranges(3, 1, 1, 1);
        compare_ranges(1, 8, 1, 1);
        compare_ranges(1, 1, 1, 8);
        compare_ranges(POS_MAX, POS_MAX, POS_MAX, POS_MAX);
        compare_ranges(0, POS_MAX, POS_MAX, 0);
        send_request(REQ_UNUSED, 8'hFF, shc_pkg::POS_W'(POS_MAX), shc_pkg::POS_W'(POS_MAX),
                     shc_pkg::POS_W'(POS_MAX), shc_pkg::POS_W'(POS_MAX));
        clear_string();
        compare_ranges(1, 1, 1, 1);
        compare_ranges(1, 0, 1, 0);
    endtask

    task automatic test_hash_bases();
        shc_pkg::word_t base_choice [0:5];
        base_choice[0] = 64'd1;
        base_choice[1] = 64'd0;
        base_choice[2] = {shc_pkg::WORD_W{1'b1}};
        base_choice[3] = 64'h8000_0000_0000_0000;
        base_choice[4] = {$urandom, $urandom};
        base_choice[5] = shc_pkg::BASE_RESET;
        for (int i = 0; i <= 5; i++)
        begin
            load_hash_base(base_choice[i]);
            clear_string();
            append_random_word(24, 2);
            repeat (12) compare_random_ranges(10);
        end
    endtask

    task automatic test_full_store();
        logic [shc_pkg::CHAR_W-1:0] motif [0:15];
        for (int i = 0; i < 16; i++)
            motif[i] = shc_pkg::CHAR_W'(97 + $urandom_range(0, 3));
        load_hash_base({$urandom, $urandom});
        clear_string();
        send_idle_on = 1'b0;
        for (int i = 0; i < MAX_LEN; i++)
            append_char(motif[i % 16]);
        send_idle_on = 1'b1;
        // store full: both appends are dropped
        append_char(8'd97);
        append_char(8'd255);
        compare_ranges(1, MAX_LEN, 1, MAX_LEN);
        compare_ranges(1, MAX_LEN / 2, MAX_LEN / 2 + 1, MAX_LEN);
        compare_ranges(1, MAX_LEN - 16, 17, MAX_LEN);
        compare_ranges(1, MAX_LEN - 1, 2, MAX_LEN);
        compare_ranges(MAX_LEN + 1, MAX_LEN, 1, 0);
        compare_ranges(1, MAX_LEN + 1, 1, 1);
        compare_ranges(MAX_LEN, MAX_LEN, 16, 16);
        repeat (10) compare_random_ranges(0);
        clear_string();
        append_char(8'd122);
        compare_ranges(1, 1, 1, 1);
        compare_ranges(1, 1, 2, 2);
    endtask

    task automatic test_random_traffic();
        int goal;
        int next_switch;
        int pick;
        goal        = items_sent + RANDOM_ITEMS;
        next_switch = items_sent;
        while (items_sent < goal)
        begin
            if (items_sent >= next_switch)
            begin
                case ($urandom_range(0, 3))
                    0:       load_hash_base(shc_pkg::BASE_RESET);
                    1:       load_hash_base({$urandom, $urandom});
                    2:       load_hash_base(shc_pkg::WORD_W'($urandom_range(2, 300)));
                    default: load_hash_base({$urandom, $urandom} | 64'd1);
                endcase
                clear_string();
                next_switch  = items_sent + PHASE_ITEMS;
                send_idle_on = ($urandom_range(0, 3) != 0);
                take_idle_on = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 6)
                send_request(shc_pkg::REQ_W'($urandom_range(0, 3)),
                             shc_pkg::CHAR_W'($urandom_range(0, 255)),
                             random_pos(), random_pos(), random_pos(), random_pos());
            else if (pick < 9 || model_len > 200)
                clear_string();
            else if (pick < 50)
                append_random_word($urandom_range(1, 12), $urandom_range(1, 4));
            else
                compare_random_ranges(15);
        end
    endtask

    initial
    begin : result_checker
        int       stall;
        verdict_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait(take_idle_on);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            if (expected_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item: equal %b, flag %b",
                                          ranges_equal, error_flag));
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (ranges_equal !== want.ranges_equal)
                    report_mismatch($sformatf("ranges_equal %b, predicted %b",
                                              ranges_equal, want.ranges_equal));
                if (error_flag !== want.error_flag)
                    report_mismatch($sformatf("error_flag %b, predicted %b",
                                              error_flag, want.error_flag));
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        req_type        = shc_pkg::REQ_APPEND;
        char_code       = '0;
        first_left      = '0;
        first_right     = '0;
        second_left     = '0;
        second_right    = '0;
        out_ready       = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        model_base      = shc_pkg::BASE_RESET;
        model_prefix[0] = shc_pkg::HASH_EMPTY;
        model_power[0]  = shc_pkg::POW_EMPTY;
        model_len       = 0;
        mismatches      = 0;
        items_sent      = 0;
        send_idle_on    = 1'b1;
        take_idle_on    = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_hash_bases();
        test_full_store();
        test_random_traffic();
        drain_and_settle();

        if (mismatches == 0)
            $display("[substring_hash_compare_unit] OK");
        else
            $display("[substring_hash_compare_unit] ERROR");
        $finish;
    end

endmodule
